FILE: rtl/ato_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ato_pkg
// Shared widths, codes and constants of the annealing tour optimizer.
// ----------------------------------------------------------------------------
package ato_pkg;

	localparam int MAX_CITY_COUNT_DEF = 1024;
	localparam int IDX_EXT_W          = 13;

	localparam int FUNC_W    = 3;
	localparam int SLOT_W    = 10;
	localparam int COORD_W   = 24;
	localparam int RAND_W    = 16;
	localparam int COST_W    = 35;
	localparam int TEMP_W    = 24;
	localparam int COOL_W    = 16;
	localparam int COUNT_W   = 11;
	localparam int S_DATA_W  = 104;
	localparam int M_DATA_W  = 48;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 24;

	// Function codes
	localparam logic [FUNC_W-1:0] FUNC_LOAD_CITY = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_TOUR = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_START     = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_ANNEAL    = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_READ      = 3'd4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CITY_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_TEMP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COOLING    = 2'd2;

	localparam logic [COUNT_W-1:0] CITY_COUNT_RST = 11'd1024;
	localparam logic [TEMP_W-1:0]  START_TEMP_RST = 24'd256000;
	localparam logic [COOL_W-1:0]  COOLING_RST    = 16'd65208;

	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
	// ln2 in Q.16, and the reduction count past which a rise is rejected
	localparam logic [50:0] LN2_Q16   = 51'd45426;
	localparam int          K_LAST    = 16;
	localparam int          TAYLOR_N  = 12;

endpackage

FILE: rtl/annealing_tour_optimizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annealing_tour_optimizer
// Simulated annealing over a closed tour: loads, tour length, swap and accept.
// ----------------------------------------------------------------------------
// One item is in flight at a time. A load goes straight to the output stage
// and a read first fetches the tour entry. A start item walks the tour once:
// per edge two memory reads, two squarings on the shared multiplier and a
// 25-step square root. An anneal item with valid swap slots adds a swap,
// the same tour walk, then for a rise in cost at a nonzero temperature a
// divide, up to 17 range reduction steps and twelve Taylor terms (each one
// multiply and one divide on the shared divider), a revert of the swap if
// the rise is rejected, and cooling. The walk over the tour sets the rate.
// The input is not ready while an item is in work; a finished result sits
// in the output register and the next item may enter while it waits.
// ----------------------------------------------------------------------------
module annealing_tour_optimizer
	import ato_pkg::*;
#(
	parameter int MAX_CITY_COUNT = MAX_CITY_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	// input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// slot_index[9:0], coord_x[33:10], coord_y[57:34], tour_entry[67:58],
	// swap_first[77:68], swap_second[87:78], uniform_random[103:88]
	input  logic [S_DATA_W-1:0]  s_tdata,
	// func[2:0]
	input  logic [FUNC_W-1:0]    s_tuser,
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// accepted[0], tour_cost[35:1], tour_city[45:36], zero fill [47:46]
	output logic [M_DATA_W-1:0]  m_tdata
);

	localparam int CW = $clog2(MAX_CITY_COUNT);
	localparam int NW = CW + 1;
	localparam logic [IDX_EXT_W-1:0] MAX_EXT = IDX_EXT_W'(MAX_CITY_COUNT);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_RDA    = 5'd1;
	localparam logic [4:0] S_RDW    = 5'd2;
	localparam logic [4:0] S_SWA    = 5'd3;
	localparam logic [4:0] S_SWB    = 5'd4;
	localparam logic [4:0] S_SWW    = 5'd5;
	localparam logic [4:0] S_SWW2   = 5'd6;
	localparam logic [4:0] S_LINIT  = 5'd7;
	localparam logic [4:0] S_LCRD   = 5'd8;
	localparam logic [4:0] S_LCOORD = 5'd9;
	localparam logic [4:0] S_LNEXT  = 5'd10;
	localparam logic [4:0] S_LMX    = 5'd11;
	localparam logic [4:0] S_LMY    = 5'd12;
	localparam logic [4:0] S_LMS    = 5'd13;
	localparam logic [4:0] S_SQRT   = 5'd14;
	localparam logic [4:0] S_ACC    = 5'd15;
	localparam logic [4:0] S_DECIDE = 5'd16;
	localparam logic [4:0] S_DIV    = 5'd17;
	localparam logic [4:0] S_KRED   = 5'd18;
	localparam logic [4:0] S_TMUL   = 5'd19;
	localparam logic [4:0] S_TMW    = 5'd20;
	localparam logic [4:0] S_TADD   = 5'd21;
	localparam logic [4:0] S_PCMP   = 5'd22;
	localparam logic [4:0] S_RVA    = 5'd23;
	localparam logic [4:0] S_RVB    = 5'd24;
	localparam logic [4:0] S_COOL   = 5'd25;
	localparam logic [4:0] S_COOLW  = 5'd26;
	localparam logic [4:0] S_OUT    = 5'd27;

	// control state
	logic [4:0]          state_q, state_d;
	logic [COUNT_W-1:0]  city_count_q;
	logic [TEMP_W-1:0]   start_temp_q;
	logic [COOL_W-1:0]   cooling_q;
	logic [COST_W-1:0]   cost_q;
	logic [TEMP_W-1:0]   temp_q;

	// item fields
	logic [FUNC_W-1:0]   func_q;
	logic [SLOT_W-1:0]   idx_q, swap_a_q, swap_b_q;
	logic [RAND_W-1:0]   rand_q;
	logic                acc_q;
	logic [SLOT_W-1:0]   city_q;

	// memories
	logic [COORD_W-1:0]  x_mem [MAX_CITY_COUNT];
	logic [COORD_W-1:0]  y_mem [MAX_CITY_COUNT];
	logic [SLOT_W-1:0]   tour_mem [MAX_CITY_COUNT];
	logic [COORD_W-1:0]  x_rd_q, y_rd_q;
	logic [SLOT_W-1:0]   tour_rd_q;
	logic                tour_we;
	logic [CW-1:0]       tour_waddr, tour_raddr, coord_raddr, coord_waddr;
	logic [SLOT_W-1:0]   tour_wdata;
	logic                coord_we;

	// tour walk
	logic [NW-1:0]       slot_q;
	logic                closing_q, oob_q;
	logic [SLOT_W-1:0]   va_q, vb_q;
	logic [COORD_W-1:0]  px_q, py_q, fx_q, fy_q, dx_q, dy_q;
	logic [47:0]         sq_q;
	logic [48:0]         v_q, res_q, bit_q;
	logic [COST_W-1:0]   sum_q, fresh_q;

	// shared multiplier
	logic [32:0]         mul_a;
	logic [23:0]         mul_b;
	logic [56:0]         mul_q;

	// shared divider
	logic [50:0]         quo_q;
	logic [23:0]         rem_q, den_q;
	logic [5:0]          div_cnt_q;
	logic                div_mode_q;

	// acceptance
	logic [50:0]         g_q;
	logic [4:0]          k_q;
	logic [3:0]          n_q;
	logic [32:0]         term_q;
	logic signed [34:0]  e_q;

	// combinational helpers
	logic                s_acc;
	logic [SLOT_W-1:0]   in_idx, in_entry, in_a, in_b;
	logic [COORD_W-1:0]  in_x, in_y;
	logic [RAND_W-1:0]   in_rand;
	logic                in_idx_ok;
	logic [IDX_EXT_W-1:0] used_n;
	logic                swap_ok;
	logic [COORD_W-1:0]  cur_x, cur_y;
	logic [NW-1:0]       slot_nx;
	logic                slot_last;
	logic [49:0]         sq_trial;
	logic                sq_take;
	logic [35:0]         sum_raw;
	logic [COST_W-1:0]   sum_sat;
	logic [24:0]         rem_sh;
	logic                div_ge;
	logic [50:0]         quo_nx;
	logic [23:0]         rem_nx;
	logic [34:0]         e_pos;
	logic [34:0]         chance;
	logic                chance_hit;

	assign in_idx   = s_tdata[9:0];
	assign in_x     = s_tdata[33:10];
	assign in_y     = s_tdata[57:34];
	assign in_entry = s_tdata[67:58];
	assign in_a     = s_tdata[77:68];
	assign in_b     = s_tdata[87:78];
	assign in_rand  = s_tdata[103:88];

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign in_idx_ok = IDX_EXT_W'(in_idx) < MAX_EXT;

	// clamp the count into 2..MAX
	always_comb begin
		priority if (city_count_q < 11'd2) begin
			used_n = IDX_EXT_W'(2);
		end else if (IDX_EXT_W'(city_count_q) > MAX_EXT) begin
			used_n = MAX_EXT;
		end else begin
			used_n = IDX_EXT_W'(city_count_q);
		end
	end

	assign swap_ok   = (IDX_EXT_W'(in_a) < used_n) && (IDX_EXT_W'(in_b) < used_n);
	assign cur_x     = oob_q ? '0 : x_rd_q;
	assign cur_y     = oob_q ? '0 : y_rd_q;
	assign slot_nx   = slot_q + 1'b1;
	assign slot_last = IDX_EXT_W'(slot_nx) == used_n;

	// one square root step: bit walks down two places a cycle
	assign sq_trial = {1'b0, res_q} + {1'b0, bit_q};
	assign sq_take  = {1'b0, v_q} >= sq_trial;

	assign sum_raw = {1'b0, sum_q} + 36'(res_q[24:0]);
	assign sum_sat = (sum_raw > {1'b0, COST_MAX}) ? COST_MAX : sum_raw[COST_W-1:0];

	// one restoring divide step
	assign rem_sh = {rem_q, quo_q[50]};
	assign div_ge = rem_sh >= {1'b0, den_q};
	assign rem_nx = div_ge ? 24'(rem_sh - {1'b0, den_q}) : rem_sh[23:0];
	assign quo_nx = {quo_q[49:0], div_ge};

	assign e_pos      = e_q[34] ? '0 : e_q;
	assign chance     = e_pos >> (6'd16 + 6'(k_q));
	assign chance_hit = chance > 35'(rand_q);

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_LMX: begin
				mul_a = 33'(dx_q);
				mul_b = dx_q;
			end
			S_LMY: begin
				mul_a = 33'(dy_q);
				mul_b = dy_q;
			end
			S_TMUL: begin
				mul_a = term_q;
				mul_b = 24'(g_q[15:0]);
			end
			S_COOL: begin
				mul_a = 33'(temp_q);
				mul_b = 24'(cooling_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// memory port select
	always_comb begin
		tour_we     = 1'b0;
		tour_waddr  = CW'(in_idx);
		tour_wdata  = in_entry;
		tour_raddr  = '0;
		coord_we    = s_acc && (s_tuser == FUNC_LOAD_CITY) && in_idx_ok;
		coord_waddr = CW'(in_idx);
		coord_raddr = CW'(tour_rd_q);
		unique case (state_q)
			S_IDLE: begin
				tour_we = s_acc && (s_tuser == FUNC_LOAD_TOUR) && in_idx_ok;
			end
			S_RDA:   tour_raddr = CW'(idx_q);
			S_SWA:   tour_raddr = CW'(swap_a_q);
			S_SWB:   tour_raddr = CW'(swap_b_q);
			S_SWW: begin
				tour_we    = 1'b1;
				tour_waddr = CW'(swap_a_q);
				tour_wdata = tour_rd_q;
			end
			S_SWW2: begin
				tour_we    = 1'b1;
				tour_waddr = CW'(swap_b_q);
				tour_wdata = va_q;
			end
			S_RVA: begin
				tour_we    = 1'b1;
				tour_waddr = CW'(swap_a_q);
				tour_wdata = va_q;
			end
			S_RVB: begin
				tour_we    = 1'b1;
				tour_waddr = CW'(swap_b_q);
				tour_wdata = vb_q;
			end
			S_LINIT: tour_raddr = '0;
			S_LNEXT: tour_raddr = slot_nx[CW-1:0];
			default: tour_raddr = '0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					unique case (s_tuser)
						FUNC_READ:   state_d = S_RDA;
						FUNC_START:  state_d = S_LINIT;
						FUNC_ANNEAL: state_d = swap_ok ? S_SWA : S_COOL;
						default:     state_d = S_OUT;
					endcase
				end
			end
			S_RDA:    state_d = S_RDW;
			S_RDW:    state_d = S_OUT;
			S_SWA:    state_d = S_SWB;
			S_SWB:    state_d = S_SWW;
			S_SWW:    state_d = S_SWW2;
			S_SWW2:   state_d = S_LINIT;
			S_LINIT:  state_d = S_LCRD;
			S_LCRD:   state_d = S_LCOORD;
			S_LCOORD: state_d = (slot_q == '0) ? S_LNEXT : S_LMX;
			S_LNEXT:  state_d = slot_last ? S_LMX : S_LCRD;
			S_LMX:    state_d = S_LMY;
			S_LMY:    state_d = S_LMS;
			S_LMS:    state_d = S_SQRT;
			S_SQRT:   state_d = bit_q[0] ? S_ACC : S_SQRT;
			S_ACC: begin
				priority if (!closing_q) begin
					state_d = S_LNEXT;
				end else if (func_q == FUNC_START) begin
					state_d = S_OUT;
				end else begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				priority if (fresh_q < cost_q) begin
					state_d = S_COOL;
				end else if (temp_q == '0) begin
					state_d = S_RVA;
				end else begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (div_cnt_q == 6'd50) begin
					state_d = div_mode_q ? S_TADD : S_KRED;
				end
			end
			S_KRED: begin
				priority if (g_q < LN2_Q16) begin
					state_d = S_TMUL;
				end else if (k_q == 5'(K_LAST)) begin
					state_d = S_RVA;
				end else begin
					state_d = S_KRED;
				end
			end
			S_TMUL:   state_d = S_TMW;
			S_TMW:    state_d = S_DIV;
			S_TADD:   state_d = (n_q == 4'(TAYLOR_N)) ? S_PCMP : S_TMUL;
			S_PCMP:   state_d = chance_hit ? S_COOL : S_RVA;
			S_RVA:    state_d = S_RVB;
			S_RVB:    state_d = S_COOL;
			S_COOL:   state_d = S_COOLW;
			S_COOLW:  state_d = S_OUT;
			S_OUT:    state_d = (!m_tvalid || m_tready) ? S_IDLE : S_OUT;
			default:  state_d = S_IDLE;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (tour_we) begin
			tour_mem[tour_waddr] <= tour_wdata;
		end
		tour_rd_q <= tour_mem[tour_raddr];
	end

	always_ff @(posedge clk) begin
		if (coord_we) begin
			x_mem[coord_waddr] <= in_x;
			y_mem[coord_waddr] <= in_y;
		end
		x_rd_q <= x_mem[coord_raddr];
		y_rd_q <= y_mem[coord_raddr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			city_count_q <= CITY_COUNT_RST;
			start_temp_q <= START_TEMP_RST;
			cooling_q    <= COOLING_RST;
			cost_q       <= '0;
			temp_q       <= '0;
			m_tvalid     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_CITY_COUNT: city_count_q <= cfg_data[COUNT_W-1:0];
					REG_START_TEMP: start_temp_q <= cfg_data;
					REG_COOLING:    cooling_q    <= cfg_data[COOL_W-1:0];
					default: ;
				endcase
			end
			// commit the new cost on start, on a fall, or on a lucky rise
			if (state_q == S_ACC && closing_q && func_q == FUNC_START) begin
				cost_q <= sum_sat;
				temp_q <= start_temp_q;
			end
			if ((state_q == S_DECIDE && fresh_q < cost_q) ||
				(state_q == S_PCMP && chance_hit)) begin
				cost_q <= fresh_q;
			end
			if (state_q == S_COOLW) begin
				temp_q <= mul_q[39:16];
			end
			if (state_q == S_OUT && (!m_tvalid || m_tready)) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		unique case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					func_q   <= s_tuser;
					idx_q    <= in_idx;
					swap_a_q <= in_a;
					swap_b_q <= in_b;
					rand_q   <= in_rand;
					acc_q    <= 1'b0;
					city_q   <= '0;
				end
			end
			S_RDW: begin
				city_q <= (IDX_EXT_W'(idx_q) < MAX_EXT) ? tour_rd_q : '0;
			end
			S_SWB: va_q <= tour_rd_q;
			S_SWW: vb_q <= tour_rd_q;
			S_LINIT: begin
				slot_q    <= '0;
				sum_q     <= '0;
				closing_q <= 1'b0;
			end
			S_LCRD: begin
				oob_q <= IDX_EXT_W'(tour_rd_q) >= MAX_EXT;
			end
			S_LCOORD: begin
				if (slot_q == '0) begin
					fx_q <= cur_x;
					fy_q <= cur_y;
				end
				dx_q <= (px_q > cur_x) ? px_q - cur_x : cur_x - px_q;
				dy_q <= (py_q > cur_y) ? py_q - cur_y : cur_y - py_q;
				px_q <= cur_x;
				py_q <= cur_y;
			end
			S_LNEXT: begin
				slot_q <= slot_nx;
				if (slot_last) begin
					// close the loop back to slot 0
					closing_q <= 1'b1;
					dx_q <= (px_q > fx_q) ? px_q - fx_q : fx_q - px_q;
					dy_q <= (py_q > fy_q) ? py_q - fy_q : fy_q - py_q;
				end
			end
			S_LMY: sq_q <= mul_q[47:0];
			S_LMS: begin
				v_q   <= {1'b0, sq_q} + {1'b0, mul_q[47:0]};
				res_q <= '0;
				bit_q <= 49'd1 << 48;
			end
			S_SQRT: begin
				if (sq_take) begin
					v_q   <= 49'({1'b0, v_q} - sq_trial);
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_ACC: begin
				sum_q   <= sum_sat;
				fresh_q <= sum_sat;
			end
			S_DECIDE: begin
				if (fresh_q < cost_q) begin
					acc_q <= 1'b1;
				end
				quo_q      <= {fresh_q - cost_q, 16'd0};
				den_q      <= temp_q;
				rem_q      <= '0;
				div_cnt_q  <= '0;
				div_mode_q <= 1'b0;
			end
			S_DIV: begin
				quo_q     <= quo_nx;
				rem_q     <= rem_nx;
				div_cnt_q <= div_cnt_q + 1'b1;
				if (div_cnt_q == 6'd50) begin
					if (div_mode_q) begin
						term_q <= quo_nx[32:0];
					end else begin
						g_q <= quo_nx;
						k_q <= '0;
					end
				end
			end
			S_KRED: begin
				if (g_q >= LN2_Q16) begin
					g_q <= g_q - LN2_Q16;
					k_q <= k_q + 1'b1;
				end else begin
					n_q    <= 4'd1;
					term_q <= 33'd1 << 32;
					e_q    <= 35'sd1 <<< 32;
				end
			end
			S_TMW: begin
				quo_q      <= 51'(mul_q[47:16]);
				den_q      <= 24'(n_q);
				rem_q      <= '0;
				div_cnt_q  <= '0;
				div_mode_q <= 1'b1;
			end
			S_TADD: begin
				// alternate the sign of the series terms
				if (n_q[0]) begin
					e_q <= e_q - $signed({2'b00, term_q});
				end else begin
					e_q <= e_q + $signed({2'b00, term_q});
				end
				n_q <= n_q + 1'b1;
			end
			S_PCMP: begin
				acc_q <= chance_hit;
			end
			S_OUT: begin
				if (!m_tvalid || m_tready) begin
					m_tdata <= {2'b00, city_q, cost_q, acc_q};
				end
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	// an accepted item always leaves idle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q != S_IDLE))
		else $error("item accepted but sequencer stayed idle");

	// the root step bit stays a single bit while iterating
	a_sqrt_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQRT) |-> $onehot(bit_q))
		else $error("square root step bit lost");

	// range reduction never passes the cut-off
	a_kred_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_KRED) |-> (k_q <= 5'(K_LAST)))
		else $error("range reduction count overran");

	// the cost only moves at a commit point
	a_cost_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(cost_q != $past(cost_q)) |-> ($past(state_q) == S_ACC ||
			$past(state_q) == S_DECIDE || $past(state_q) == S_PCMP))
		else $error("tour cost changed outside a commit");
`endif

endmodule

FILE: tb/annealing_tour_optimizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annealing_tour_optimizer_tb
// Self-checking bench: loads cities and tours, runs start and anneal steps
// under several register settings, and checks every result against a
// fixed-point predictor of tour length, acceptance and cooling.
// ----------------------------------------------------------------------------
module annealing_tour_optimizer_tb;
	import ato_pkg::*;

	localparam int  NCITY = MAX_CITY_COUNT_DEF;
	// longest quiet stretch: a 16-city walk plus the acceptance math, many times over
	localparam int  IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [RAND_W-1:0]  uniform;
		logic [SLOT_W-1:0]  swap_b;
		logic [SLOT_W-1:0]  swap_a;
		logic [SLOT_W-1:0]  entry;
		logic [COORD_W-1:0] cy;
		logic [COORD_W-1:0] cx;
		logic [SLOT_W-1:0]  slot;
	} op_t;

	typedef struct packed {
		logic [SLOT_W-1:0] city;
		logic [COST_W-1:0] cost;
		logic              kept;
	} outcome_t;

	// Tracks the block's state and holds the outcomes still owed by it.
	class tour_scoreboard;
		bit [COORD_W-1:0] xs[NCITY];
		bit [COORD_W-1:0] ys[NCITY];
		bit [SLOT_W-1:0]  tour[NCITY];
		bit [COST_W-1:0]  cost;
		bit [TEMP_W-1:0]  temp;
		bit [COUNT_W-1:0] count;
		bit [TEMP_W-1:0]  start_temp;
		bit [COOL_W-1:0]  cool;
		outcome_t         owed[$];
		int               errors;

		function new();
			count = CITY_COUNT_RST;
			start_temp = START_TEMP_RST;
			cool = COOLING_RST;
			cost = '0;
			temp = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
			case (idx)
				REG_CITY_COUNT: count = val[COUNT_W-1:0];
				REG_START_TEMP: start_temp = val[TEMP_W-1:0];
				REG_COOLING:    cool = val[COOL_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned live_count();
			if (count < 2) return 2;
			if (count > NCITY) return NCITY;
			return count;
		endfunction

		function longint unsigned isqrt(longint unsigned v);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		function longint unsigned walk_length();
			longint unsigned sum, dx, dy;
			int unsigned n, nxt, ca, cb;
			n = live_count();
			sum = 0;
			for (int unsigned i = 0; i < n; i++) begin
				nxt = (i + 1 == n) ? 0 : i + 1;
				ca = tour[i];
				cb = tour[nxt];
				dx = (xs[ca] > xs[cb]) ? xs[ca] - xs[cb] : xs[cb] - xs[ca];
				dy = (ys[ca] > ys[cb]) ? ys[ca] - ys[cb] : ys[cb] - ys[ca];
				sum += isqrt(dx * dx + dy * dy);
				if (sum > COST_MAX) sum = COST_MAX;
			end
			return sum;
		endfunction

		// exp(-d/t) in Q0.16 by range reduction over ln2 and a Taylor sum
		function longint unsigned uphill_chance(longint unsigned d, longint unsigned t);
			longint unsigned r, k, g, term;
			longint e;
			r = (d << 16) / t;
			k = r / 45426;
			g = r - k * 45426;
			term = 64'd1 << 32;
			e = longint'(term);
			if (k >= 17) return 0;
			for (int n = 1; n <= 12; n++) begin
				term = (term * g) / (longint'(n) << 16);
				if (n % 2) e -= longint'(term);
				else e += longint'(term);
			end
			if (e < 0) e = 0;
			return longint'(e) >> (16 + k);
		endfunction

		function void note_input(op_t op);
			outcome_t o;
			longint unsigned fresh;
			bit keep;
			bit [SLOT_W-1:0] hold;
			int unsigned n;
			o = '0;
			case (op.func)
				FUNC_LOAD_CITY: begin
					xs[op.slot] = op.cx;
					ys[op.slot] = op.cy;
				end
				FUNC_LOAD_TOUR: tour[op.slot] = op.entry;
				FUNC_START: begin
					cost = walk_length();
					temp = start_temp;
				end
				FUNC_ANNEAL: begin
					n = live_count();
					if (op.swap_a < n && op.swap_b < n) begin
						hold = tour[op.swap_a];
						tour[op.swap_a] = tour[op.swap_b];
						tour[op.swap_b] = hold;
						fresh = walk_length();
						if (fresh < cost) keep = 1;
						else if (temp == 0) keep = 0;
						else keep = uphill_chance(fresh - cost, temp) > op.uniform;
						if (keep) begin
							cost = fresh;
							o.kept = 1'b1;
						end else begin
							hold = tour[op.swap_a];
							tour[op.swap_a] = tour[op.swap_b];
							tour[op.swap_b] = hold;
						end
					end
					temp = TEMP_W'((64'(temp) * cool) >> 16);
				end
				FUNC_READ: o.city = tour[op.slot];
				default: ;
			endcase
			o.cost = cost;
			owed.push_back(o);
		endfunction

		function void check_result(logic [M_DATA_W-1:0] word);
			outcome_t want, got;
			got = word[45:0];
			if (owed.size() == 0) begin
				$display("%0t: result with nothing expected, actual %h", $time, word);
				errors++;
				return;
			end
			want = owed.pop_front();
			if (got.kept !== want.kept) begin
				$display("%0t: accepted expected %0d actual %0d", $time, want.kept, got.kept);
				errors++;
			end
			if (got.cost !== want.cost) begin
				$display("%0t: tour_cost expected %0d actual %0d", $time, want.cost, got.cost);
				errors++;
			end
			if (got.city !== want.city) begin
				$display("%0t: tour_city expected %0d actual %0d", $time, want.city, got.city);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata;
	logic [FUNC_W-1:0]    s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_DATA_W-1:0]  m_tdata;

	tour_scoreboard sb;
	int burst_left;
	int ready_pct;
	int pattern_cnt;
	int idle_cycles;

	annealing_tour_optimizer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Receiver: switch between always ready, light and heavy stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			pattern_cnt <= 0;
			ready_pct <= 100;
		end else begin
			pattern_cnt <= pattern_cnt + 1;
			if (pattern_cnt % 97 == 0) begin
				case ($urandom_range(0, 2))
					0: ready_pct <= 100;
					1: ready_pct <= 60;
					default: ready_pct <= 20;
				endcase
			end
			m_tready <= ($urandom_range(0, 99) < ready_pct);
		end
	end

	// Check every result transaction and watch for a stuck block.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("annealing_tour_optimizer_tb NOT OK");
				$finish;
			end
		end else begin
			idle_cycles <= 0;
		end
	end

	// Hand one item to the block; bursts of random length with gaps between.
	task automatic send_op(op_t op);
		int gap;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {op.uniform, op.swap_b, op.swap_a, op.entry, op.cy, op.cx, op.slot};
		s_tuser  <= op.func;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_input(op);
		burst_left--;
	endtask

	// Hold the input until every owed result has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(int cnt, int t0, int cf);
		write_reg(REG_CITY_COUNT, CFG_DAT_W'(cnt));
		write_reg(REG_START_TEMP, CFG_DAT_W'(t0));
		write_reg(REG_COOLING, CFG_DAT_W'(cf));
	endtask

	function automatic op_t make_op(logic [FUNC_W-1:0] f);
		op_t op;
		op.func    = f;
		op.slot    = $urandom;
		op.cx      = $urandom;
		op.cy      = $urandom;
		op.entry   = $urandom;
		op.swap_a  = $urandom;
		op.swap_b  = $urandom;
		op.uniform = $urandom;
		return op;
	endfunction

	function automatic op_t anneal_op(int a, int b, int u);
		op_t op;
		op = make_op(FUNC_ANNEAL);
		op.swap_a = a;
		op.swap_b = b;
		op.uniform = u;
		return op;
	endfunction

	function automatic op_t slot_op(logic [FUNC_W-1:0] f, int slot, int entry);
		op_t op;
		op = make_op(f);
		op.slot = slot;
		op.entry = entry;
		return op;
	endfunction

	initial begin
		op_t op;
		int cnt, span;
		sb = new();
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		burst_left = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Keep every walk inside the first 16 tour slots, all of them loaded below.
		configure(8, 256000, 65208);

		// Low cities sit close together so uphill moves have a real chance.
		for (int i = 0; i < 16; i++) begin
			op = make_op(FUNC_LOAD_CITY);
			op.slot = i;
			op.cx = $urandom_range(0, 4095);
			op.cy = $urandom_range(0, 4095);
			send_op(op);
		end
		// Two extreme cities for the widest possible edge.
		op = make_op(FUNC_LOAD_CITY);
		op.slot = 1023; op.cx = '1; op.cy = '1;
		send_op(op);
		op.slot = 1022; op.cx = '0; op.cy = '0;
		send_op(op);
		for (int i = 0; i < 16; i++)
			send_op(slot_op(FUNC_LOAD_TOUR, i, $urandom_range(0, 15)));

		// Anneal before any start: zero temperature.
		send_op(anneal_op(3, 5, 0));
		send_op(make_op(FUNC_START));
		drain();

		// Two extreme cities on a two-city tour.
		configure(2, 24'hFFFFFF, 16'hFFFF);
		send_op(slot_op(FUNC_LOAD_TOUR, 0, 1023));
		send_op(slot_op(FUNC_LOAD_TOUR, 1, 1022));
		send_op(make_op(FUNC_START));
		send_op(anneal_op(0, 1, 0));
		send_op(anneal_op(1, 1, 16'hFFFF));
		send_op(anneal_op(2, 0, 5));
		send_op(anneal_op(1023, 1023, 5));
		send_op(slot_op(FUNC_READ, 0, 0));
		send_op(slot_op(FUNC_READ, 1, 0));
		send_op(make_op(3'd5));
		send_op(make_op(3'd6));
		send_op(make_op(3'd7));
		drain();

		// Counts below the floor, tiny temperature, a zero cooling factor.
		configure(0, 1, 0);
		send_op(make_op(FUNC_START));
		send_op(anneal_op(0, 1, 0));
		send_op(anneal_op(0, 1, 0));
		drain();
		configure(1, 200, 65535);
		send_op(make_op(FUNC_START));
		send_op(anneal_op(1, 0, 100));
		drain();
		configure(16, 256000, 65208);
		send_op(make_op(FUNC_START));
		send_op(anneal_op(15, 0, 30000));
		drain();

		// Random phases: fresh tour over the close cities, start, then a mix.
		for (int phase = 0; phase < 3; phase++) begin
			cnt = $urandom_range(2, 8);
			configure(cnt, ($urandom_range(0, 3) == 0) ?
				$urandom_range(1, 24'hFFFFFF) : $urandom_range(1, 20000),
				($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(60000, 65535));
			cnt = sb.live_count();
			span = (cnt < 16) ? cnt : 16;
			for (int i = 0; i < span; i++)
				send_op(slot_op(FUNC_LOAD_TOUR, i, $urandom_range(0, 15)));
			send_op(make_op(FUNC_START));
			for (int j = 0; j < 8; j++) begin
				case ($urandom_range(0, 19))
					0, 1, 2: send_op(slot_op(FUNC_READ, $urandom_range(0, 15), 0));
					3: begin
						op = make_op(FUNC_LOAD_CITY);
						if ($urandom_range(0, 1)) begin
							op.slot = $urandom_range(0, 15);
							op.cx = $urandom_range(0, 4095);
							op.cy = $urandom_range(0, 4095);
						end
						send_op(op);
					end
					4: send_op(slot_op(FUNC_LOAD_TOUR, $urandom_range(0, span - 1),
						$urandom_range(0, 15)));
					5: send_op(make_op($urandom_range(0, 1) ? FUNC_START : 3'($urandom_range(5, 7))));
					6: send_op(make_op(FUNC_ANNEAL));
					default: send_op(anneal_op($urandom_range(0, span - 1),
						$urandom_range(0, span - 1), $urandom));
				endcase
			end
			// hold off until the block has caught up, then change settings
			drain();
		end

		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("annealing_tour_optimizer_tb OK");
		else
			$display("annealing_tour_optimizer_tb NOT OK");
		$finish;
	end

endmodule
